>>> hw/rtl/mlfd_pkg.sv
// Shared types and constants of the magic/length frame decoder.
package mlfd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HDR_CNT_W = 3;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_MAGIC = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 1'd1;

  localparam logic [WORD_W-1:0] FRAME_MAGIC_RESET = 32'h0000_0000;
  localparam logic [WORD_W-1:0] MAX_PAYLOAD_RESET = 32'h0001_0000;

  // Header byte positions: bytes up to MAGIC_LAST form the magic word
  localparam logic [HDR_CNT_W-1:0] MAGIC_LAST  = 3'd3;
  localparam logic [HDR_CNT_W-1:0] HEADER_LAST = 3'd7;

  // Error causes
  localparam logic ERR_BAD_MAGIC  = 1'b0;
  localparam logic ERR_BAD_LENGTH = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_end;
    logic              empty_frame;
    logic              framing_error;
    logic              error_cause;
  } out_item_t;

endpackage

>>> hw/rtl/mlfd_stream_if.sv
// Valid/ready stream channel carrying one payload item per transaction.
interface mlfd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/magic_length_frame_decoder.sv
// Each result is loaded into the output register as its byte is accepted.
// Throughput: one byte per cycle; the single output register is refilled in the cycle
// it is taken, so input stalls only while a result waits unaccepted downstream.
// Reset (rst, synchronous): header parser restarts, error cleared, output emptied,
// frame_magic returns to 0 and max_payload to 65536.
module magic_length_frame_decoder
  import mlfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  mlfd_stream_if.sink            rx,
  mlfd_stream_if.source          tx
);

  // Configuration registers
  logic [WORD_W-1:0] frame_magic;
  logic [WORD_W-1:0] max_payload;

  // Parser state
  logic                 in_payload;
  logic [HDR_CNT_W-1:0] header_count;
  logic [WORD_W-1:0]    magic_shift;
  logic [WORD_W-1:0]    length_shift;
  logic [WORD_W-1:0]    bytes_left;
  logic                 error_latched;

  // Output register
  logic      out_valid;
  out_item_t out_item;

  // Next-state and result of the byte on the input
  logic                 in_payload_next;
  logic [HDR_CNT_W-1:0] header_count_next;
  logic [WORD_W-1:0]    magic_shift_next;
  logic [WORD_W-1:0]    length_shift_next;
  logic [WORD_W-1:0]    bytes_left_next;
  logic                 error_latched_next;
  logic                 res_valid;
  out_item_t            res_item;
  logic [BYTE_W-1:0]    b;
  logic                 accept;

  assign b        = rx.payload.data_byte;
  assign rx.ready = !out_valid || tx.ready;
  assign accept   = rx.valid && rx.ready;

  assign tx.valid   = out_valid;
  assign tx.payload = out_item;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic <= FRAME_MAGIC_RESET;
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_MAGIC: frame_magic <= cfg_data;
        REG_MAX_PAYLOAD: max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode one byte against the parser state
  always_comb begin
    in_payload_next    = in_payload;
    header_count_next  = header_count;
    magic_shift_next   = magic_shift;
    length_shift_next  = length_shift;
    bytes_left_next    = bytes_left;
    error_latched_next = error_latched;
    res_valid          = 1'b0;
    res_item           = '0;

    if (error_latched) begin
      // drop everything until reset
    end else if (in_payload) begin
      bytes_left_next       = bytes_left - 1'b1;
      res_valid             = 1'b1;
      res_item.payload_byte = b;
      if (bytes_left == {{(WORD_W-1){1'b0}}, 1'b1}) begin
        in_payload_next    = 1'b0;
        res_item.frame_end = 1'b1;
      end
    end else begin
      if (header_count <= MAGIC_LAST) begin
        magic_shift_next = {magic_shift[WORD_W-BYTE_W-1:0], b};
      end else begin
        length_shift_next = {length_shift[WORD_W-BYTE_W-1:0], b};
      end

      if (header_count != HEADER_LAST) begin
        header_count_next = header_count + 1'b1;
      end else begin
        // Header complete: check magic first, then length
        header_count_next = '0;
        res_valid         = 1'b1;
        if (magic_shift != frame_magic) begin
          error_latched_next     = 1'b1;
          res_item.framing_error = 1'b1;
          res_item.error_cause   = ERR_BAD_MAGIC;
        end else if (length_shift_next > max_payload) begin
          error_latched_next     = 1'b1;
          res_item.framing_error = 1'b1;
          res_item.error_cause   = ERR_BAD_LENGTH;
        end else if (length_shift_next == '0) begin
          res_item.empty_frame = 1'b1;
        end else begin
          res_valid       = 1'b0;
          in_payload_next = 1'b1;
          bytes_left_next = length_shift_next;
        end
      end
    end
  end

  // Advance parser state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload    <= 1'b0;
      header_count  <= '0;
      magic_shift   <= '0;
      length_shift  <= '0;
      bytes_left    <= '0;
      error_latched <= 1'b0;
    end else if (accept) begin
      in_payload    <= in_payload_next;
      header_count  <= header_count_next;
      magic_shift   <= magic_shift_next;
      length_shift  <= length_shift_next;
      bytes_left    <= bytes_left_next;
      error_latched <= error_latched_next;
    end
  end

  // Hold the result until taken; load a new one when a transaction yields it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_item <= res_item;
    end
  end

endmodule

>>> tb/sv/magic_length_frame_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the magic/length frame decoder.
module magic_length_frame_decoder_tb;
  import mlfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum int unsigned {FAULT_MAGIC, FAULT_LENGTH, FAULT_BOTH} fault_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0]      cfg_data;

  mlfd_stream_if #(.payload_t(in_item_t))  rx_if ();
  mlfd_stream_if #(.payload_t(out_item_t)) tx_if ();

  magic_length_frame_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_if),
    .tx        (tx_if)
  );

  // Decoder state mirrored by the predictor
  logic                 dec_in_payload = 1'b0;
  logic [HDR_CNT_W-1:0] dec_hdr_idx    = '0;
  logic [WORD_W-1:0]    dec_magic      = '0;
  logic [WORD_W-1:0]    dec_length     = '0;
  logic [WORD_W-1:0]    dec_left       = '0;
  logic                 dec_locked     = 1'b0;
  logic [WORD_W-1:0]    cur_magic      = FRAME_MAGIC_RESET;
  logic [WORD_W-1:0]    cur_max        = MAX_PAYLOAD_RESET;

  out_item_t   decoded_q[$];
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned bytes_sent    = 0;
  int unsigned frames_sent   = 0;
  int unsigned cycles        = 0;
  int unsigned dropped_bytes = 0;
  fault_t      fault_kind    = FAULT_MAGIC;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up if the run stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited", cycles, decoded_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Downstream back-pressure
  always @(posedge clk) begin
    tx_if.ready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
  end

  // Work out the result, if any, that one accepted byte causes
  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    out_item_t r;
    r = '0;
    if (dec_locked) return;
    if (dec_in_payload) begin
      dec_left       = dec_left - 1;
      r.payload_byte = b;
      r.frame_end    = (dec_left == 0);
      if (dec_left == 0) dec_in_payload = 1'b0;
      decoded_q = {decoded_q, r};
      return;
    end
    if (dec_hdr_idx <= MAGIC_LAST) dec_magic = {dec_magic[WORD_W-BYTE_W-1:0], b};
    else dec_length = {dec_length[WORD_W-BYTE_W-1:0], b};
    if (dec_hdr_idx != HEADER_LAST) begin
      dec_hdr_idx = dec_hdr_idx + 1'b1;
      return;
    end
    dec_hdr_idx = '0;
    if (dec_magic != cur_magic) begin
      dec_locked      = 1'b1;
      r.framing_error = 1'b1;
      r.error_cause   = ERR_BAD_MAGIC;
      decoded_q = {decoded_q, r};
    end else if (dec_length > cur_max) begin
      dec_locked      = 1'b1;
      r.framing_error = 1'b1;
      r.error_cause   = ERR_BAD_LENGTH;
      decoded_q = {decoded_q, r};
    end else if (dec_length == 0) begin
      r.empty_frame = 1'b1;
      decoded_q = {decoded_q, r};
    end else begin
      dec_in_payload = 1'b1;
      dec_left       = dec_length;
    end
  endfunction

  function automatic void report_fault(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Compare every output transaction with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && tx_if.valid && tx_if.ready) begin
      got = tx_if.payload;
      results_seen++;
      if (decoded_q.size() == 0) begin
        report_fault($sformatf("unexpected result byte=%02h end=%0b empty=%0b err=%0b cause=%0b",
                               got.payload_byte, got.frame_end, got.empty_frame,
                               got.framing_error, got.error_cause));
      end else begin
        want = decoded_q.pop_front();
        if (got.payload_byte !== want.payload_byte || got.frame_end !== want.frame_end ||
            got.empty_frame !== want.empty_frame || got.framing_error !== want.framing_error ||
            got.error_cause !== want.error_cause) begin
          report_fault($sformatf({"result %0d: expected byte=%02h end=%0b empty=%0b err=%0b ",
                                  "cause=%0b, got byte=%02h end=%0b empty=%0b err=%0b cause=%0b"},
                                 results_seen, want.payload_byte, want.frame_end,
                                 want.empty_frame, want.framing_error, want.error_cause,
                                 got.payload_byte, got.frame_end, got.empty_frame,
                                 got.framing_error, got.error_cause));
        end
      end
    end
  end

  // Offer one byte, idling first at random, and hold it until it is taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.payload <= b;
    do @(posedge clk); while (!rx_if.ready);
    bytes_sent++;
    decode_byte(b);
  endtask

  task automatic send_header(input logic [WORD_W-1:0] magic, input logic [WORD_W-1:0] len);
    logic [2*WORD_W-1:0] hdr;
    hdr = {magic, len};
    frames_sent++;
    for (int i = 7; i >= 0; i--) send_byte(hdr[i*BYTE_W +: BYTE_W]);
  endtask

  task automatic send_frame(input logic [WORD_W-1:0] magic, input logic [WORD_W-1:0] len);
    send_header(magic, len);
    for (int unsigned i = 0; i < len; i++) send_byte(BYTE_W'($urandom));
  endtask

  // Register write; the strobe drops on the following cycle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_FRAME_MAGIC) cur_magic = val;
    else cur_max = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, let every predicted result drain, then allow for header bytes in flight
  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly short payloads, now and then a longer one or exactly the maximum
  function automatic logic [WORD_W-1:0] pick_length();
    logic [WORD_W-1:0] cap;
    cap = (cur_max < 24) ? cur_max : 24;
    if (cur_max <= 120 && $urandom_range(7) == 0) return cur_max;
    if (cur_max >= 120 && $urandom_range(9) == 0) cap = 120;
    return $urandom_range(cap, 0);
  endfunction

  // Reset values of both registers: magic 0 accepted, one-byte frame and empty frame
  task automatic test_reset_values();
    send_header(FRAME_MAGIC_RESET, 1);
    send_byte(8'hFF);
    send_header(FRAME_MAGIC_RESET, 0);
  endtask

  // All-ones magic and a length equal to the maximum, payload at both byte extremes
  task automatic test_frame_basics();
    wait_idle();
    write_reg(REG_FRAME_MAGIC, '1);
    write_reg(REG_MAX_PAYLOAD, 2);
    send_header('1, 2);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // Well-formed frames under eight register settings and four flow-control phases
  task automatic test_random_frames();
    int unsigned stop;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 65; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 65; end
        default: begin src_idle_pct = 8;  snk_stall_pct = 8;  end
      endcase
      for (int half = 0; half < 2; half++) begin
        wait_idle();
        case (ph * 2 + half)
          0: begin write_reg(REG_FRAME_MAGIC, $urandom); write_reg(REG_MAX_PAYLOAD, '1); end
          1: begin write_reg(REG_FRAME_MAGIC, '0); write_reg(REG_MAX_PAYLOAD, '0); end
          2: begin
            write_reg(REG_FRAME_MAGIC, '1);
            write_reg(REG_MAX_PAYLOAD, $urandom_range(30, 1));
          end
          3: begin
            write_reg(REG_FRAME_MAGIC, $urandom);
            write_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD_RESET);
          end
          4: begin write_reg(REG_FRAME_MAGIC, $urandom); write_reg(REG_MAX_PAYLOAD, 1); end
          5: begin
            write_reg(REG_FRAME_MAGIC, $urandom);
            write_reg(REG_MAX_PAYLOAD, $urandom_range(200, 0));
          end
          6: begin write_reg(REG_FRAME_MAGIC, '0); write_reg(REG_MAX_PAYLOAD, '1); end
          default: begin
            write_reg(REG_FRAME_MAGIC, '1);
            write_reg(REG_MAX_PAYLOAD, $urandom_range(150, 24));
          end
        endcase
        stop = bytes_sent + 85;
        while (bytes_sent < stop) send_frame(cur_magic, pick_length());
      end
    end
  endtask

  // One bad header latches the error; everything after it must vanish
  task automatic test_sticky_error();
    logic [WORD_W-1:0] bad_magic;
    logic [WORD_W-1:0] bad_len;
    int unsigned       mark;
    wait_idle();
    write_reg(REG_FRAME_MAGIC, $urandom);
    write_reg(REG_MAX_PAYLOAD, $urandom_range(40, 0));
    send_frame(cur_magic, pick_length());
    fault_kind = fault_t'($urandom_range(2));
    bad_magic  = cur_magic ^ (32'h1 << $urandom_range(31));
    bad_len    = $urandom_range(1) ? '1 : cur_max + 1;
    case (fault_kind)
      FAULT_MAGIC:  send_header(bad_magic, pick_length());
      FAULT_LENGTH: send_header(cur_magic, bad_len);
      default:      send_header(bad_magic, bad_len);
    endcase
    // A clean frame and noise: all of it must be dropped
    mark = bytes_sent;
    send_frame(cur_magic, 4);
    send_header(cur_magic, 0);
    repeat (24) send_byte(BYTE_W'($urandom));
    dropped_bytes = bytes_sent - mark;
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_FRAME_MAGIC;
    cfg_data      <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.payload <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_frame_basics();
    test_random_frames();
    test_sticky_error();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0)
      report_fault($sformatf("%0d predicted results never appeared", decoded_q.size()));

    $display("Sent %0d frames in %0d bytes, checked %0d results under 8 register settings",
             frames_sent, bytes_sent, results_seen);
    $display("Sticky error raised by %s, %0d later bytes dropped; %0d mismatches",
             fault_kind.name(), dropped_bytes, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/mlfd_pkg.sv
hw/rtl/mlfd_stream_if.sv
hw/rtl/magic_length_frame_decoder.sv
tb/sv/magic_length_frame_decoder_tb.sv
